@@ sv/assert_macros.svh @@
// Assertion macros used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define TXBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define TXBP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TXBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TXBP_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ sv/txbp_pkg.sv @@
// Shared types and constants for the transmit buffer pool manager.
package txbp_pkg;

  localparam int TXBP_SLOT_COUNT      = 4;
  localparam int TXBP_MAX_FRAME_BYTES = 2048;

  localparam int FUNC_W = 3;
  localparam int LEN_W  = 12;
  localparam int SLOT_PORT_W = 2;
  localparam int CNT_W  = 32;

  // Event codes
  localparam logic [FUNC_W-1:0] FN_RESERVE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUBLISH = 3'd1;
  localparam logic [FUNC_W-1:0] FN_START   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DONE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FAULT   = 3'd4;

  // Slot states
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;

  // Latched fault codes
  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_SAMPLING = 2'd1;
  localparam logic [1:0] FAULT_TX_DMA   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic commit;   // apply the event, load the result register
  } txbp_cmd_t;

endpackage

@@ sv/tx_buffer_pool_manager.sv @@
// Transmit buffer pool manager: top level joining controller and datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction:
//   reserve, publish, try start, transmit done or fault, with its operands.
//   Result channel (out_valid / out_stall) returns exactly one transaction
//   per event: reserve and start outcomes plus a snapshot of busy, fault and
//   the three 32-bit wrapping counters after the event.
// Sequence: the accepted input is captured, then executed once the result
//   register is free, which loads the result and raises out_valid.
// Flow: the capture-then-execute sequence in the controller keeps one event
//   in flight at a time. A new input is taken while the previous result
//   still waits.
// Reset (rst_n low, synchronous): all slots free, pointers cleared, no
//   fault latched, counters zero, out_valid low. Stored lengths are not
//   cleared; a slot is only read after it has been published.
// Receiver stall: the result register holds; the next event waits in the
//   execute step and no pool state changes until the result is taken.
module tx_buffer_pool_manager
  import txbp_pkg::*;
#(
  parameter int SLOT_COUNT      = TXBP_SLOT_COUNT,
  parameter int MAX_FRAME_BYTES = TXBP_MAX_FRAME_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic                   in_is_data_frame,
  input  logic [SLOT_PORT_W-1:0] in_slot,
  input  logic [LEN_W-1:0]       in_frame_length,
  input  logic                   in_fault_kind,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_reserve_ok,
  output logic [SLOT_PORT_W-1:0] out_reserved_slot,
  output logic                   out_start_ok,
  output logic [SLOT_PORT_W-1:0] out_started_slot,
  output logic [LEN_W-1:0]       out_started_length,
  output logic                   out_transmitter_busy,
  output logic [1:0]             out_fault_state,
  output logic [CNT_W-1:0]       out_data_drops,
  output logic [CNT_W-1:0]       out_control_drops,
  output logic [CNT_W-1:0]       out_frames_sent
);

  txbp_cmd_t cmd;

  // Sequencer: accepts a transaction, then commits it once the result
  // register is free or being drained.
  txbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot table, scans, counters and the result register.
  txbp_dp #(
    .SLOT_COUNT      (SLOT_COUNT),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_func              (in_func),
    .in_is_data_frame     (in_is_data_frame),
    .in_slot              (in_slot),
    .in_frame_length      (in_frame_length),
    .in_fault_kind        (in_fault_kind),
    .out_reserve_ok       (out_reserve_ok),
    .out_reserved_slot    (out_reserved_slot),
    .out_start_ok         (out_start_ok),
    .out_started_slot     (out_started_slot),
    .out_started_length   (out_started_length),
    .out_transmitter_busy (out_transmitter_busy),
    .out_fault_state      (out_fault_state),
    .out_data_drops       (out_data_drops),
    .out_control_drops    (out_control_drops),
    .out_frames_sent      (out_frames_sent)
  );

endmodule

@@ sv/txbp_ctrl.sv @@
// Sequencing controller: input capture, execute, result handshake.
module txbp_ctrl
  import txbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output txbp_cmd_t  cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // Result register can take a new transaction this cycle
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/txbp_dp.sv @@
// Datapath: slot table, pointers, fault latch, counters and result register.
`include "assert_macros.svh"

module txbp_dp
  import txbp_pkg::*;
#(
  parameter int SLOT_COUNT      = TXBP_SLOT_COUNT,
  parameter int MAX_FRAME_BYTES = TXBP_MAX_FRAME_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  txbp_cmd_t              cmd,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic                   in_is_data_frame,
  input  logic [SLOT_PORT_W-1:0] in_slot,
  input  logic [LEN_W-1:0]       in_frame_length,
  input  logic                   in_fault_kind,
  output logic                   out_reserve_ok,
  output logic [SLOT_PORT_W-1:0] out_reserved_slot,
  output logic                   out_start_ok,
  output logic [SLOT_PORT_W-1:0] out_started_slot,
  output logic [LEN_W-1:0]       out_started_length,
  output logic                   out_transmitter_busy,
  output logic [1:0]             out_fault_state,
  output logic [CNT_W-1:0]       out_data_drops,
  output logic [CNT_W-1:0]       out_control_drops,
  output logic [CNT_W-1:0]       out_frames_sent
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int SUM_W  = SLOT_W + 1;

  // Captured transaction
  logic [FUNC_W-1:0]      func_r;
  logic                   is_data_r;
  logic [SLOT_PORT_W-1:0] slot_r;
  logic [LEN_W-1:0]       len_r;
  logic                   fkind_r;

  // Pool state
  logic [1:0]        status_r [SLOT_COUNT];
  logic [1:0]        status_nxt [SLOT_COUNT];
  logic [LEN_W-1:0]  length_r [SLOT_COUNT];
  logic [SLOT_W-1:0] next_fill_r, next_fill_nxt;
  logic [SLOT_W-1:0] active_slot_r, active_slot_nxt;
  logic              active_valid_r, active_valid_nxt;
  logic              busy_r, busy_nxt;
  logic [1:0]        fault_r, fault_nxt;
  logic [CNT_W-1:0]  data_drop_r, data_drop_nxt;
  logic [CNT_W-1:0]  ctrl_drop_r, ctrl_drop_nxt;
  logic [CNT_W-1:0]  sent_r, sent_nxt;

  // Per-event result register
  logic                   res_ok_r;
  logic [SLOT_PORT_W-1:0] res_slot_r;
  logic                   st_ok_r;
  logic [SLOT_PORT_W-1:0] st_slot_r;
  logic [LEN_W-1:0]       st_len_r;

  logic              res_hit;
  logic [SLOT_W-1:0] res_idx;
  logic              rdy_hit;
  logic [SLOT_W-1:0] rdy_idx;
  logic              start_go;
  logic              pub_ok;
  logic [SLOT_W-1:0] pub_idx;
  logic [LEN_W-1:0]  pub_len;
  logic              do_reserve, do_publish, do_start, do_done, do_fault;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= in_func;
      is_data_r <= in_is_data_frame;
      slot_r    <= in_slot;
      len_r     <= in_frame_length;
      fkind_r   <= in_fault_kind;
    end
  end

  // Round-robin free search from next_fill; lowest offset wins
  always_comb begin
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] cand;
    res_hit = 1'b0;
    res_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      sum = {1'b0, next_fill_r} + SUM_W'(i);
      if (sum >= SUM_W'(SLOT_COUNT)) sum = sum - SUM_W'(SLOT_COUNT);
      cand = sum[SLOT_W-1:0];
      if (status_r[cand] == ST_FREE) begin
        res_hit = 1'b1;
        res_idx = cand;
      end
    end
  end

  // Lowest ready slot
  always_comb begin
    rdy_hit = 1'b0;
    rdy_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (status_r[i] == ST_READY) begin
        rdy_hit = 1'b1;
        rdy_idx = SLOT_W'(i);
      end
    end
  end

  assign do_reserve = cmd.commit && (func_r == FN_RESERVE);
  assign do_publish = cmd.commit && (func_r == FN_PUBLISH);
  assign do_start   = cmd.commit && (func_r == FN_START);
  assign do_done    = cmd.commit && (func_r == FN_DONE);
  assign do_fault   = cmd.commit && (func_r == FN_FAULT);

  assign start_go = rdy_hit && (fault_r == FAULT_NONE) && !busy_r;
  assign pub_ok   = (32'(slot_r) < 32'(SLOT_COUNT));
  assign pub_idx  = SLOT_W'(slot_r);
  assign pub_len  = (32'(len_r) > 32'(MAX_FRAME_BYTES)) ? LEN_W'(MAX_FRAME_BYTES) : len_r;

  always_comb begin
    status_nxt       = status_r;
    next_fill_nxt    = next_fill_r;
    active_slot_nxt  = active_slot_r;
    active_valid_nxt = active_valid_r;
    busy_nxt         = busy_r;
    fault_nxt        = fault_r;
    data_drop_nxt    = data_drop_r;
    ctrl_drop_nxt    = ctrl_drop_r;
    sent_nxt         = sent_r;

    if (do_reserve && !res_hit) begin
      if (is_data_r) data_drop_nxt = data_drop_r + CNT_W'(1);
      else           ctrl_drop_nxt = ctrl_drop_r + CNT_W'(1);
    end
    if (do_publish && pub_ok) begin
      status_nxt[pub_idx] = ST_READY;
      next_fill_nxt = (pub_idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : pub_idx + SLOT_W'(1);
    end
    if (do_start && start_go) begin
      status_nxt[rdy_idx] = ST_ACTIVE;
      busy_nxt            = 1'b1;
      active_slot_nxt     = rdy_idx;
      active_valid_nxt    = 1'b1;
    end
    if (do_done) begin
      if (active_valid_r) status_nxt[active_slot_r] = ST_FREE;
      active_valid_nxt = 1'b0;
      active_slot_nxt  = '0;
      busy_nxt         = 1'b0;
      sent_nxt         = sent_r + CNT_W'(1);
    end
    if (do_fault && (fault_r == FAULT_NONE)) begin
      fault_nxt = fkind_r ? FAULT_TX_DMA : FAULT_SAMPLING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) status_r[i] <= ST_FREE;
      next_fill_r    <= '0;
      active_slot_r  <= '0;
      active_valid_r <= 1'b0;
      busy_r         <= 1'b0;
      fault_r        <= FAULT_NONE;
      data_drop_r    <= '0;
      ctrl_drop_r    <= '0;
      sent_r         <= '0;
    end else begin
      status_r       <= status_nxt;
      next_fill_r    <= next_fill_nxt;
      active_slot_r  <= active_slot_nxt;
      active_valid_r <= active_valid_nxt;
      busy_r         <= busy_nxt;
      fault_r        <= fault_nxt;
      data_drop_r    <= data_drop_nxt;
      ctrl_drop_r    <= ctrl_drop_nxt;
      sent_r         <= sent_nxt;
    end
  end

  // Length store: no reset, only read for slots that were published
  always_ff @(posedge clk) begin
    if (do_publish && pub_ok) length_r[pub_idx] <= pub_len;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_ok_r   <= do_reserve && res_hit;
      res_slot_r <= (do_reserve && res_hit) ? SLOT_PORT_W'(res_idx) : '0;
      st_ok_r    <= do_start && start_go;
      st_slot_r  <= (do_start && start_go) ? SLOT_PORT_W'(rdy_idx) : '0;
      st_len_r   <= (do_start && start_go) ? length_r[rdy_idx] : '0;
    end
  end

  // Status fields come straight from state: it only moves on commit
  assign out_reserve_ok       = res_ok_r;
  assign out_reserved_slot    = res_slot_r;
  assign out_start_ok         = st_ok_r;
  assign out_started_slot     = st_slot_r;
  assign out_started_length   = st_len_r;
  assign out_transmitter_busy = busy_r;
  assign out_fault_state      = fault_r;
  assign out_data_drops       = data_drop_r;
  assign out_control_drops    = ctrl_drop_r;
  assign out_frames_sent      = sent_r;

  `TXBP_ASSERT(a_busy_tracks_active, clk, rst_n, busy_r == active_valid_r, "busy and active disagree")
  `TXBP_ASSERT(a_start_sets_busy, clk, rst_n, do_start && start_go |=> busy_r, "start did not set busy")
  `TXBP_ASSERT(a_fault_sticky, clk, rst_n, fault_r != FAULT_NONE |=> $stable(fault_r), "fault code changed")
  `TXBP_NEVER(a_no_commit_on_capture, clk, rst_n, cmd.capture && cmd.commit, "capture and commit overlap")

endmodule
